@@ src/mhsp_pkg.sv @@
// Shared types and constants for the mail header stream parser.
`default_nettype none
package mhsp_pkg;

  // Payload widths of the request and result channels
  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned HdrW  = 3;
  localparam int unsigned CodeW = 2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KindW-1:0] KIND_END   = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [CodeW-1:0] ERR_UNKNOWN   = 2'd0;
  localparam logic [CodeW-1:0] ERR_DUPLICATE = 2'd1;
  localparam logic [CodeW-1:0] ERR_TRUNCATED = 2'd2;

  // Header kinds
  localparam int unsigned NumLabels = 6;
  localparam int unsigned MaxLabel  = 14;
  localparam logic [HdrW-1:0] HDR_DATE    = 3'd0;

  localparam logic [ByteW-1:0] BYTE_CR = 8'h0D;
  localparam logic [ByteW-1:0] BYTE_LF = 8'h0A;

  // Label text, one row per header kind, zero padded
  localparam logic [ByteW-1:0] LABEL_TEXT [NumLabels][MaxLabel] = '{
    '{"D", "a", "t", "e", ":", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00},
    '{"T", "o", ":", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{"C", "C", ":", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{"F", "r", "o", "m", ":", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00},
    '{"O", "r", "g", "a", "n", "i", "z", "a", "t", "i", "o", "n", ":", " "},
    '{"S", "u", "b", "j", "e", "c", "t", ":", " ", 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00}
  };
  localparam logic [3:0] LABEL_LEN [NumLabels] = '{
    4'd6, 4'd4, 4'd4, 4'd6, 4'd14, 4'd9
  };

  // One result item
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [HdrW-1:0]  header_kind;
    logic [ByteW-1:0] value_data;
    logic [CodeW-1:0] error_code;
    logic             buffer_end;
  } result_t;

endpackage
`default_nettype wire

@@ src/mhsp_in_if.sv @@
// Request channel carrying header buffer bytes.
`default_nettype none
interface mhsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [mhsp_pkg::ByteW-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ src/mhsp_out_if.sv @@
// Result channel carrying value bytes, value ends and errors.
`default_nettype none
interface mhsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [mhsp_pkg::KindW-1:0]  kind;
  logic [mhsp_pkg::HdrW-1:0]   header_kind;
  logic [mhsp_pkg::ByteW-1:0]  value_data;
  logic [mhsp_pkg::CodeW-1:0]  error_code;
  logic                        buffer_end;

  modport source (output valid, output kind, output header_kind, output value_data,
                  output error_code, output buffer_end, input ready);
  modport sink   (input valid, input kind, input header_kind, input value_data,
                  input error_code, input buffer_end, output ready);
endinterface
`default_nettype wire

@@ src/mail_header_stream_parser.sv @@
// Mail header stream parser: label match, value streaming and error reporting.
//
// Takes one header buffer byte per cycle on the bytes channel and matches the
// six labels Date, To, CC, From, Organization and Subject in parallel. Value
// bytes come out tagged with their header kind, a CR LF pair gives a value
// end, and errors (unknown label, repeated header, truncated buffer) come out
// once, after which bytes are dropped up to the buffer's last byte. Each byte
// is handled in the cycle it is accepted and gives zero, one or two results,
// which enter a four-entry result queue; the results channel drains one per
// cycle while its ready is high. A new byte is taken every cycle while the
// queue holds two or fewer results, so the sustained rate is one byte per
// cycle, and a held CR released with the following byte makes it give two.
`default_nettype none
module mail_header_stream_parser (
  input  wire logic      clk,
  input  wire logic      rst,
  mhsp_in_if.sink        bytes,
  mhsp_out_if.source     results
);

  typedef enum logic [1:0] {
    PH_LABEL   = 2'd0,
    PH_VALUE   = 2'd1,
    PH_HELD_CR = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  localparam int unsigned QDepth = 4;

  // Parser state
  phase_t      phase, phase_next;
  logic [3:0]  label_position, label_position_next;
  logic [5:0]  candidate_mask, candidate_mask_next;
  logic [5:0]  seen_mask, seen_mask_next;
  logic [2:0]  current_kind, current_kind_next;

  // Result queue
  mhsp_pkg::result_t queue [QDepth];
  logic [1:0]  head;
  logic [2:0]  count, count_next;

  logic        accept, pop;
  logic [1:0]  res_count;
  mhsp_pkg::result_t res0, res1;

  logic [5:0]  match_mask;
  logic        done_hit;
  logic [2:0]  done_kind;
  logic [7:0]  b;
  logic        last;

  function automatic mhsp_pkg::result_t make_res(
    input logic [mhsp_pkg::KindW-1:0] kind,
    input logic [mhsp_pkg::HdrW-1:0]  hk,
    input logic [mhsp_pkg::ByteW-1:0] data,
    input logic [mhsp_pkg::CodeW-1:0] code,
    input logic                       bend
  );
    mhsp_pkg::result_t r;
    r.kind        = kind;
    r.header_kind = hk;
    r.value_data  = data;
    r.error_code  = code;
    r.buffer_end  = bend;
    return r;
  endfunction

  assign bytes.ready = (count < 3'd3);
  assign accept      = bytes.valid && bytes.ready;
  assign pop         = results.valid && results.ready;
  assign b           = bytes.data_byte;
  assign last        = bytes.last_byte;

  // Parallel label compare at the current position
  always_comb begin
    match_mask = '0;
    done_hit   = 1'b0;
    done_kind  = mhsp_pkg::HDR_DATE;
    for (int k = 0; k < mhsp_pkg::NumLabels; k++) begin
      if (candidate_mask[k] && (label_position < mhsp_pkg::LABEL_LEN[k]) &&
          (mhsp_pkg::LABEL_TEXT[k][label_position] == b)) begin
        match_mask[k] = 1'b1;
        if (({1'b0, label_position} + 5'd1) == {1'b0, mhsp_pkg::LABEL_LEN[k]}) begin
          done_hit  = 1'b1;
          done_kind = 3'(k);
        end
      end
    end
  end

  // Per-byte decisions and next state
  always_comb begin
    phase_next          = phase;
    label_position_next = label_position;
    candidate_mask_next = candidate_mask;
    seen_mask_next      = seen_mask;
    current_kind_next   = current_kind;
    res_count           = 2'd0;
    res0                = '0;
    res1                = '0;

    unique case (phase)
      PH_LABEL: begin
        if (match_mask == '0) begin
          res0       = make_res(mhsp_pkg::KIND_ERROR, mhsp_pkg::HDR_DATE, '0,
                                mhsp_pkg::ERR_UNKNOWN, last);
          res_count  = 2'd1;
          phase_next = PH_SKIP;
        end else if (done_hit) begin
          if (seen_mask[done_kind]) begin
            res0       = make_res(mhsp_pkg::KIND_ERROR, done_kind, '0,
                                  mhsp_pkg::ERR_DUPLICATE, last);
            res_count  = 2'd1;
            phase_next = PH_SKIP;
          end else if (last) begin
            res0      = make_res(mhsp_pkg::KIND_ERROR, done_kind, '0,
                                 mhsp_pkg::ERR_TRUNCATED, 1'b1);
            res_count = 2'd1;
          end else begin
            seen_mask_next            = seen_mask;
            seen_mask_next[done_kind] = 1'b1;
            current_kind_next         = done_kind;
            phase_next                = PH_VALUE;
          end
        end else if (last) begin
          res0      = make_res(mhsp_pkg::KIND_ERROR, mhsp_pkg::HDR_DATE, '0,
                               mhsp_pkg::ERR_TRUNCATED, 1'b1);
          res_count = 2'd1;
        end else begin
          candidate_mask_next = match_mask;
          label_position_next = label_position + 4'd1;
        end
      end
      PH_VALUE: begin
        if (last) begin
          res0      = make_res(mhsp_pkg::KIND_ERROR, current_kind, '0,
                               mhsp_pkg::ERR_TRUNCATED, 1'b1);
          res_count = 2'd1;
        end else if (b == mhsp_pkg::BYTE_CR) begin
          phase_next = PH_HELD_CR;
        end else begin
          res0      = make_res(mhsp_pkg::KIND_BYTE, current_kind, b,
                               mhsp_pkg::ERR_UNKNOWN, 1'b0);
          res_count = 2'd1;
        end
      end
      PH_HELD_CR: begin
        if (b == mhsp_pkg::BYTE_LF) begin
          res0                = make_res(mhsp_pkg::KIND_END, current_kind, '0,
                                         mhsp_pkg::ERR_UNKNOWN, last);
          res_count           = 2'd1;
          phase_next          = PH_LABEL;
          label_position_next = '0;
          candidate_mask_next = '1;
        end else if (last) begin
          res0      = make_res(mhsp_pkg::KIND_ERROR, current_kind, '0,
                               mhsp_pkg::ERR_TRUNCATED, 1'b1);
          res_count = 2'd1;
        end else begin
          // release the held CR, then treat this byte as value data
          res0 = make_res(mhsp_pkg::KIND_BYTE, current_kind, mhsp_pkg::BYTE_CR,
                          mhsp_pkg::ERR_UNKNOWN, 1'b0);
          if (b == mhsp_pkg::BYTE_CR) begin
            res_count = 2'd1;
          end else begin
            res1       = make_res(mhsp_pkg::KIND_BYTE, current_kind, b,
                                  mhsp_pkg::ERR_UNKNOWN, 1'b0);
            res_count  = 2'd2;
            phase_next = PH_VALUE;
          end
        end
      end
      PH_SKIP: begin
        // drop bytes until the end of the buffer
      end
      default: begin
      end
    endcase

    // buffer end returns everything to its idle values
    if (last) begin
      phase_next          = PH_LABEL;
      label_position_next = '0;
      candidate_mask_next = '1;
      seen_mask_next      = '0;
      current_kind_next   = mhsp_pkg::HDR_DATE;
    end
  end

  // Queue occupancy
  always_comb begin
    count_next = count - {2'b00, pop};
    if (accept) begin
      count_next = count_next + {1'b0, res_count};
    end
  end

  // State, queue pointers and queue contents
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LABEL;
      label_position <= '0;
      candidate_mask <= '1;
      seen_mask      <= '0;
      current_kind   <= mhsp_pkg::HDR_DATE;
      head           <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        label_position <= label_position_next;
        candidate_mask <= candidate_mask_next;
        seen_mask      <= seen_mask_next;
        current_kind   <= current_kind_next;
      end
      if (pop) begin
        head <= head + 2'd1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (res_count != 2'd0)) begin
      queue[head + count[1:0]] <= res0;
    end
    if (accept && (res_count == 2'd2)) begin
      queue[head + count[1:0] + 2'd1] <= res1;
    end
  end

  // Result channel drives from the queue head
  assign results.valid       = (count != 3'd0);
  assign results.kind        = queue[head].kind;
  assign results.header_kind = queue[head].header_kind;
  assign results.value_data  = queue[head].value_data;
  assign results.error_code  = queue[head].error_code;
  assign results.buffer_end  = queue[head].buffer_end;

`ifndef SYNTH
  // queue never overflows its four entries
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDepth))
    else $error("result queue overflow");

  // the last byte always leaves the parser at a clean label start
  a_buffer_end_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.last_byte) |=>
      (phase == PH_LABEL && seen_mask == '0 && candidate_mask == '1 &&
       label_position == '0))
    else $error("parser state not cleared at buffer end");

  // dropped bytes after an error add no results
  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_SKIP) |=> (count <= $past(count)))
    else $error("result produced while skipping");

  // a value phase always has a header marked as seen
  a_value_seen: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE || phase == PH_HELD_CR) |-> seen_mask[current_kind])
    else $error("value streaming without a seen header");
`endif

endmodule
`default_nettype wire

@@ tb/sv/mail_header_stream_parser_tb.sv @@
// Self-checking testbench for the mail header stream parser: directed rows, then random buffers.
module mail_header_stream_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Header kinds in label order
  typedef enum logic [mhsp_pkg::HdrW-1:0] {
    H_DATE, H_TO, H_CC, H_FROM, H_ORG, H_SUBJECT
  } hdr_kind_t;

  // Parser phases
  typedef enum logic [1:0] {SCAN_LABEL, SCAN_VALUE, SCAN_HELD_CR, SCAN_SKIP} scan_t;

  // One request: the byte, its last flag and an optional typed-in result
  typedef struct packed {
    logic [mhsp_pkg::ByteW-1:0] data_byte;
    logic                       last_byte;
    logic                       typed;
    mhsp_pkg::result_t          res;
  } hdr_req_t;

  localparam int QuietLimit = 2000;
  localparam int TailCycles = 20;
  localparam int ItemTarget = 1300;
  localparam int IdlePct    = 14;

  // Directed rows; typed results only where they are obvious
  localparam hdr_req_t DirRows [24] = '{
    // unknown label right after reset, then bytes dropped up to the last one
    '{"X",   1'b0, 1'b1,
      '{mhsp_pkg::KIND_ERROR, H_DATE, 8'h00, mhsp_pkg::ERR_UNKNOWN, 1'b0}},
    '{8'hFF, 1'b1, 1'b0, '0},
    // To: header with extreme value bytes, CR CR q, and a CR LF close
    '{"T",   1'b0, 1'b0, '0},
    '{"o",   1'b0, 1'b0, '0},
    '{":",   1'b0, 1'b0, '0},
    '{" ",   1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1,
      '{mhsp_pkg::KIND_BYTE, H_TO, 8'h00, mhsp_pkg::ERR_UNKNOWN, 1'b0}},
    '{8'hFF, 1'b0, 1'b1,
      '{mhsp_pkg::KIND_BYTE, H_TO, 8'hFF, mhsp_pkg::ERR_UNKNOWN, 1'b0}},
    '{mhsp_pkg::BYTE_CR, 1'b0, 1'b0, '0},
    '{mhsp_pkg::BYTE_CR, 1'b0, 1'b0, '0},
    '{"q",   1'b0, 1'b0, '0},
    '{mhsp_pkg::BYTE_CR, 1'b0, 1'b0, '0},
    '{mhsp_pkg::BYTE_LF, 1'b0, 1'b1,
      '{mhsp_pkg::KIND_END, H_TO, 8'h00, mhsp_pkg::ERR_UNKNOWN, 1'b0}},
    // repeated To: label, completed on the last byte
    '{"T",   1'b0, 1'b0, '0},
    '{"o",   1'b0, 1'b0, '0},
    '{":",   1'b0, 1'b0, '0},
    '{" ",   1'b1, 1'b1,
      '{mhsp_pkg::KIND_ERROR, H_TO, 8'h00, mhsp_pkg::ERR_DUPLICATE, 1'b1}},
    // buffer ends inside a label
    '{"C",   1'b0, 1'b0, '0},
    '{"C",   1'b1, 1'b1,
      '{mhsp_pkg::KIND_ERROR, H_DATE, 8'h00, mhsp_pkg::ERR_TRUNCATED, 1'b1}},
    // buffer ends inside a value
    '{"T",   1'b0, 1'b0, '0},
    '{"o",   1'b0, 1'b0, '0},
    '{":",   1'b0, 1'b0, '0},
    '{" ",   1'b0, 1'b0, '0},
    '{"v",   1'b1, 1'b1,
      '{mhsp_pkg::KIND_ERROR, H_TO, 8'h00, mhsp_pkg::ERR_TRUNCATED, 1'b1}}
  };

  string hdr_labels [mhsp_pkg::NumLabels] = '{
    "Date: ", "To: ", "CC: ", "From: ", "Organization: ", "Subject: "
  };

  logic clk = 1'b0;
  logic rst;

  mhsp_in_if  in_ch ();
  mhsp_out_if out_ch ();

  mail_header_stream_parser u_dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (in_ch),
    .results (out_ch)
  );

  always #4ns clk = ~clk;

  // Requests waiting to be driven and results still owed by the block
  hdr_req_t          byte_q [$];
  hdr_req_t          on_wire;
  mhsp_pkg::result_t pending_results [$];

  int idle_pct = IdlePct;
  int err_cnt = 0;
  int quiet_cycles = 0;

  // Parser state of the predictor
  scan_t                       scan_st;
  int                          lbl_pos;
  logic [5:0]                  cand_mask;
  logic [5:0]                  seen_mask;
  logic [mhsp_pkg::HdrW-1:0]   cur_hdr;

  function automatic void reset_parser();
    scan_st   = SCAN_LABEL;
    lbl_pos   = 0;
    cand_mask = '1;
    seen_mask = '0;
    cur_hdr   = H_DATE;
  endfunction

  function automatic mhsp_pkg::result_t res_of(logic [mhsp_pkg::KindW-1:0] k,
                                               logic [mhsp_pkg::HdrW-1:0] hk,
                                               logic [mhsp_pkg::ByteW-1:0] data,
                                               logic [mhsp_pkg::CodeW-1:0] code,
                                               logic fin);
    mhsp_pkg::result_t r;
    r.kind        = k;
    r.header_kind = hk;
    r.value_data  = data;
    r.error_code  = code;
    r.buffer_end  = fin;
    return r;
  endfunction

  // Results caused by one byte, with the parser state advanced
  task automatic parse_byte(input logic [mhsp_pkg::ByteW-1:0] b, input logic last,
                            output mhsp_pkg::result_t outs [$]);
    logic [5:0] hit;
    int done;
    int k;
    outs = {};
    hit = '0;
    done = -1;
    case (scan_st)
      SCAN_LABEL: begin
        // all labels matched side by side
        for (k = 0; k < mhsp_pkg::NumLabels; k++) begin
          if (cand_mask[k] && lbl_pos < hdr_labels[k].len()
              && hdr_labels[k].getc(lbl_pos) == b) begin
            hit[k] = 1'b1;
            if (lbl_pos + 1 == hdr_labels[k].len()) done = k;
          end
        end
        if (hit == '0) begin
          outs.push_back(res_of(mhsp_pkg::KIND_ERROR, H_DATE, 8'h00,
                                mhsp_pkg::ERR_UNKNOWN, last));
          scan_st = SCAN_SKIP;
        end else if (done >= 0) begin
          if (seen_mask[done]) begin
            outs.push_back(res_of(mhsp_pkg::KIND_ERROR, hdr_kind_t'(done), 8'h00,
                                  mhsp_pkg::ERR_DUPLICATE, last));
            scan_st = SCAN_SKIP;
          end else if (last) begin
            outs.push_back(res_of(mhsp_pkg::KIND_ERROR, hdr_kind_t'(done), 8'h00,
                                  mhsp_pkg::ERR_TRUNCATED, 1'b1));
          end else begin
            seen_mask[done] = 1'b1;
            cur_hdr = hdr_kind_t'(done);
            scan_st = SCAN_VALUE;
          end
        end else if (last) begin
          outs.push_back(res_of(mhsp_pkg::KIND_ERROR, H_DATE, 8'h00,
                                mhsp_pkg::ERR_TRUNCATED, 1'b1));
        end else begin
          cand_mask = hit;
          lbl_pos++;
        end
      end
      SCAN_VALUE: begin
        if (last) begin
          outs.push_back(res_of(mhsp_pkg::KIND_ERROR, cur_hdr, 8'h00,
                                mhsp_pkg::ERR_TRUNCATED, 1'b1));
        end else if (b == mhsp_pkg::BYTE_CR) begin
          scan_st = SCAN_HELD_CR;
        end else begin
          outs.push_back(res_of(mhsp_pkg::KIND_BYTE, cur_hdr, b,
                                mhsp_pkg::ERR_UNKNOWN, 1'b0));
        end
      end
      SCAN_HELD_CR: begin
        if (b == mhsp_pkg::BYTE_LF) begin
          outs.push_back(res_of(mhsp_pkg::KIND_END, cur_hdr, 8'h00,
                                mhsp_pkg::ERR_UNKNOWN, last));
          scan_st = SCAN_LABEL;
          lbl_pos = 0;
          cand_mask = '1;
        end else if (last) begin
          outs.push_back(res_of(mhsp_pkg::KIND_ERROR, cur_hdr, 8'h00,
                                mhsp_pkg::ERR_TRUNCATED, 1'b1));
        end else begin
          // lone CR is data; the new byte is a value byte again
          outs.push_back(res_of(mhsp_pkg::KIND_BYTE, cur_hdr, mhsp_pkg::BYTE_CR,
                                mhsp_pkg::ERR_UNKNOWN, 1'b0));
          if (b != mhsp_pkg::BYTE_CR) begin
            outs.push_back(res_of(mhsp_pkg::KIND_BYTE, cur_hdr, b,
                                  mhsp_pkg::ERR_UNKNOWN, 1'b0));
            scan_st = SCAN_VALUE;
          end
        end
      end
      default: ;
    endcase
    if (last) reset_parser();
  endtask

  task automatic check_field(input string name, input logic [mhsp_pkg::ByteW-1:0] want,
                             input logic [mhsp_pkg::ByteW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // Both channels: prediction on accepted requests, checks on accepted results
  always @(posedge clk) begin : chan_handling
    mhsp_pkg::result_t produced [$];
    mhsp_pkg::result_t want;
    logic took;
    if (rst) begin
      in_ch.valid   <= 1'b0;
      out_ch.ready  <= 1'b0;
      reset_parser();
    end else begin
      took = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        took = 1'b1;
        parse_byte(on_wire.data_byte, on_wire.last_byte, produced);
        if (on_wire.typed) pending_results.push_back(on_wire.res);
        else foreach (produced[i]) pending_results.push_back(produced[i]);
      end
      if (out_ch.valid && out_ch.ready) begin
        took = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d header %0d data %0d code %0d",
                 out_ch.kind, out_ch.header_kind, out_ch.value_data, out_ch.error_code);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind",        want.kind,        out_ch.kind);
          check_field("header_kind", want.header_kind, out_ch.header_kind);
          check_field("value_data",  want.value_data,  out_ch.value_data);
          check_field("error_code",  want.error_code,  out_ch.error_code);
          check_field("buffer_end",  want.buffer_end,  out_ch.buffer_end);
        end
      end
      quiet_cycles = took ? 0 : quiet_cycles + 1;

      // next request, with random gaps
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          on_wire = byte_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= on_wire.data_byte;
          in_ch.last_byte <= on_wire.last_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // Stop sending until every request is taken and every result is back
  task automatic drain();
    while (byte_q.size() != 0 || in_ch.valid || pending_results.size() != 0)
      @(negedge clk);
  endtask

  // One random buffer: mostly well-formed headers, some noise and broken ones
  task automatic make_buffer(output int counted);
    logic [mhsp_pkg::ByteW-1:0] stream [$];
    hdr_req_t item;
    int style, hdrs, h, k, i, cut, r;
    style = $urandom_range(0, 19);
    if (style == 0) begin
      repeat ($urandom_range(1, 8))
        stream.push_back(mhsp_pkg::ByteW'($urandom_range(0, 255)));
    end else begin
      hdrs = $urandom_range(1, 4);
      for (h = 0; h < hdrs; h++) begin
        k = $urandom_range(0, mhsp_pkg::NumLabels - 1);
        if (style == 1 && h == hdrs - 1) begin
          // label prefix, a stray byte, then some trailing junk
          cut = $urandom_range(0, hdr_labels[k].len() - 1);
          for (i = 0; i < cut; i++) stream.push_back(hdr_labels[k].getc(i));
          repeat ($urandom_range(1, 5))
            stream.push_back(mhsp_pkg::ByteW'($urandom_range(0, 255)));
        end else begin
          for (i = 0; i < hdr_labels[k].len(); i++) stream.push_back(hdr_labels[k].getc(i));
          repeat ($urandom_range(0, 12)) begin
            r = $urandom_range(0, 15);
            if (r < 2) stream.push_back(mhsp_pkg::BYTE_CR);
            else if (r == 2) stream.push_back(mhsp_pkg::BYTE_LF);
            else stream.push_back(mhsp_pkg::ByteW'($urandom_range(0, 255)));
          end
          stream.push_back(mhsp_pkg::BYTE_CR);
          stream.push_back(mhsp_pkg::BYTE_LF);
        end
      end
      // cut short now and then
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, stream.size());
        while (stream.size() > cut) void'(stream.pop_back());
      end
    end
    counted = stream.size();
    foreach (stream[j]) begin
      item.data_byte = stream[j];
      item.last_byte = (j == stream.size() - 1);
      item.typed     = 1'b0;
      item.res       = '0;
      byte_q.push_back(item);
    end
  endtask

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int n;
    bit paused;
    sent = 0;
    paused = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (DirRows[i]) byte_q.push_back(DirRows[i]);
    drain();

    // random buffers, fed a few at a time
    while (sent < ItemTarget) begin
      idle_pct = (sent >= 300 && sent < 650) ? 0 : IdlePct;
      if (!paused && sent >= 900) begin
        drain();
        paused = 1'b1;
      end
      make_buffer(n);
      sent += n;
      while (byte_q.size() > 16) @(negedge clk);
    end

    drain();
    repeat (TailCycles) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
